// File: rtl/core/wvcf_pkg.sv
`timescale 1ns / 1ps
package wvcf_pkg;

   localparam int CORDIC_STEPS_DEF = 16;

   // angles in 2^-16 degree
   localparam logic signed [31:0] FULL16    = 32'sd23592960;
   localparam logic signed [31:0] HALF16    = 32'sd11796480;
   localparam logic signed [31:0] QUARTER16 = 32'sd5898240;
   localparam logic signed [31:0] INV_GAIN  = 32'sd19898;

   localparam logic [15:0]       PREV_RESET   = 16'd34560;
   localparam logic [15:0]       Q97_FULL     = 16'd46080;
   localparam logic signed [8:0] CORR_RESET   = -9'sd26;
   localparam logic [8:0]        WEIGHT_RESET = 9'd16;

   localparam logic CSR_IDX_CORR   = 1'b0;
   localparam logic CSR_IDX_WEIGHT = 1'b1;

   typedef struct packed {
      logic load;
      logic step;
      logic vec;
   } cordic_ctrl_type;

   // atan(2^-i) in degrees * 65536
   function automatic logic signed [31:0] atan_lookup(input logic [4:0] idx);
      logic signed [31:0] v;
      case (idx)
         5'd0:    v = 32'sd2949120;
         5'd1:    v = 32'sd1740967;
         5'd2:    v = 32'sd919879;
         5'd3:    v = 32'sd466945;
         5'd4:    v = 32'sd234379;
         5'd5:    v = 32'sd117304;
         5'd6:    v = 32'sd58666;
         5'd7:    v = 32'sd29335;
         5'd8:    v = 32'sd14668;
         5'd9:    v = 32'sd7334;
         5'd10:   v = 32'sd3667;
         5'd11:   v = 32'sd1833;
         5'd12:   v = 32'sd917;
         5'd13:   v = 32'sd458;
         5'd14:   v = 32'sd229;
         5'd15:   v = 32'sd115;
         5'd16:   v = 32'sd57;
         5'd17:   v = 32'sd29;
         5'd18:   v = 32'sd14;
         5'd19:   v = 32'sd7;
         5'd20:   v = 32'sd4;
         5'd21:   v = 32'sd2;
         5'd22:   v = 32'sd1;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/core/wvcf_cordic.sv
`timescale 1ns / 1ps
module wvcf_cordic import wvcf_pkg::*; #(
   parameter int STEPS = CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cordic_ctrl_type    ctrl,
   input  logic signed [31:0] x_load,
   input  logic signed [31:0] y_load,
   input  logic signed [31:0] z_load,
   output logic signed [31:0] x_out,
   output logic signed [31:0] y_out,
   output logic signed [31:0] z_out,
   output logic               done
);
   localparam int CNT_W = $clog2(STEPS + 1);

   logic signed [31:0] x_ff, y_ff, z_ff, x_in, y_in, z_in, atan_v;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               pos;

   assign done   = (cnt_ff == CNT_W'(STEPS));
   assign atan_v = atan_lookup(5'(cnt_ff));
   // rotation drives z to zero, vectoring drives y to zero
   assign pos    = ctrl.vec ? y_ff[31] : !z_ff[31];

   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      z_in   = z_ff;
      cnt_in = cnt_ff;
      if (ctrl.load) begin
         x_in   = x_load;
         y_in   = y_load;
         z_in   = z_load;
         cnt_in = '0;
      end else if (ctrl.step && !done) begin
         if (pos) begin
            x_in = x_ff - (y_ff >>> cnt_ff);
            y_in = y_ff + (x_ff >>> cnt_ff);
            z_in = z_ff - atan_v;
         end else begin
            x_in = x_ff + (y_ff >>> cnt_ff);
            y_in = y_ff - (x_ff >>> cnt_ff);
            z_in = z_ff + atan_v;
         end
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

// File: rtl/core/wind_vane_circular_filter.sv
// One transaction at a time: a request is taken only in the idle state, which
//   is re-entered once the result has been written to the response register;
//   a response stall holds the block until the receiver is ready. The shared
//   CORDIC stage does two rotation passes and one vectoring pass per request,
//   and the modulo-360 loops make the time per request depend on the inputs.
// Reset (synchronous): registers to -26 deg and 16/256, filter state 270 deg.
`timescale 1ns / 1ps
module wind_vane_circular_filter import wvcf_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [8:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_raw_word,
   input  logic [15:0] req_sail_angle,
   input  logic [15:0] req_heading,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [8:0]  rsp_raw_direction,
   output logic [15:0] rsp_wind_direction
);

   typedef enum logic [18:0] {
      S_IDLE  = 19'h00001,
      S_READ  = 19'h00002,
      S_SAIL  = 19'h00004,
      S_MODS  = 19'h00008,
      S_HEAD  = 19'h00010,
      S_MODH  = 19'h00020,
      S_SEL   = 19'h00040,
      S_WRA   = 19'h00080,
      S_WRB   = 19'h00100,
      S_FOLD  = 19'h00200,
      S_ROT   = 19'h00400,
      S_ROTE  = 19'h00800,
      S_MULS  = 19'h01000,
      S_MULC  = 19'h02000,
      S_SUM   = 19'h04000,
      S_VLOAD = 19'h08000,
      S_VEC   = 19'h10000,
      S_WRAPZ = 19'h20000,
      S_FIN   = 19'h40000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic signed [8:0] corr_ff;
   logic [8:0]        weight_ff;

   // transaction registers
   logic [13:0] enc_ff;
   logic [8:0]  sail_ff, head_ff, dir_ff, dir_in;
   logic [10:0] acc_ff, acc_in;
   logic [15:0] prev_ff, prev_in;

   // angle folding ahead of each rotation pass
   logic signed [31:0] ang_ff, ang_in;
   logic               neg_ff, neg_in;
   logic               pass_ff, pass_in;   // low: previous direction, high: new sample

   logic signed [15:0] sp_ff, cp_ff, sn_ff, cn_ff;
   logic signed [25:0] prod_s_ff, prod_c_ff, prod_in;
   logic signed [18:0] ys_ff, xs_ff;
   logic               zero_ff, zero_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [8:0]  rsp_raw_ff;
   logic [15:0] rsp_dir_ff;

   // shared CORDIC stage
   cordic_ctrl_type    cctl;
   logic signed [31:0] cx_load, cy_load, cz_load, cx, cy, cz;
   logic               cdone;

   wvcf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (cctl),
      .x_load (cx_load),
      .y_load (cy_load),
      .z_load (cz_load),
      .x_out  (cx),
      .y_out  (cy),
      .z_out  (cz),
      .done   (cdone)
   );

   function automatic logic signed [15:0] clamp15(input logic signed [31:0] v);
      logic signed [15:0] r;
      if (v > 32'sd32767) begin
         r = 16'sd32767;
      end else if (v < -32'sd32767) begin
         r = -16'sd32767;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // scaled encoder reading plus correction
   logic [22:0]        enc_prod;
   logic signed [10:0] rd_sum;
   logic signed [31:0] rx, ry, vx, vy;
   logic signed [31:0] zw;
   logic [16:0]        q_sum;
   logic [15:0]        q_val;
   logic               out_free;

   assign enc_prod = 23'(enc_ff) * 23'd360;
   assign rd_sum   = $signed({2'b00, enc_prod[22:14]}) + {{2{corr_ff[8]}}, corr_ff};
   assign rx       = neg_ff ? -cx : cx;
   assign ry       = neg_ff ? -cy : cy;
   assign vx       = {{5{xs_ff[18]}}, xs_ff, 8'b0};
   assign vy       = {{5{ys_ff[18]}}, ys_ff, 8'b0};
   assign zw       = zero_ff ? 32'sd0 : ang_ff;
   assign q_sum    = 17'((zw + 32'sd256) >>> 9);
   assign q_val    = (q_sum >= 17'(Q97_FULL)) ? 16'(q_sum - 17'(Q97_FULL)) : q_sum[15:0];
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      dir_in       = dir_ff;
      prev_in      = prev_ff;
      ang_in       = ang_ff;
      neg_in       = neg_ff;
      pass_in      = pass_ff;
      zero_in      = zero_ff;
      prod_in      = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cctl         = '0;
      cx_load      = INV_GAIN;
      cy_load      = '0;
      cz_load      = ang_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            acc_in   = rd_sum[10] ? 11'(rd_sum + 11'sd360) : rd_sum;
            state_in = S_SAIL;
         end
         S_SAIL: begin
            acc_in   = acc_ff + 11'(sail_ff);
            state_in = S_MODS;
         end
         S_MODS: begin
            if (acc_ff >= 11'd360) begin
               acc_in = acc_ff - 11'd360;
            end else begin
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            acc_in   = acc_ff + 11'(head_ff);
            state_in = S_MODH;
         end
         S_MODH: begin
            if (acc_ff >= 11'd360) begin
               acc_in = acc_ff - 11'd360;
            end else begin
               dir_in   = acc_ff[8:0];
               pass_in  = 1'b0;
               state_in = S_SEL;
            end
         end
         S_SEL: begin
            ang_in   = pass_ff ? {7'b0, dir_ff, 16'b0} : {7'b0, prev_ff, 9'b0};
            state_in = S_WRA;
         end
         S_WRA: begin
            if (ang_ff >= FULL16) begin
               ang_in = ang_ff - FULL16;
            end
            state_in = S_WRB;
         end
         S_WRB: begin
            if (ang_ff > HALF16) begin
               ang_in = ang_ff - FULL16;
            end
            state_in = S_FOLD;
         end
         S_FOLD: begin
            // bring into +-90 deg, undo by negating the result
            cctl.load = 1'b1;
            if (ang_ff > QUARTER16) begin
               cz_load = ang_ff - HALF16;
               neg_in  = 1'b1;
            end else if (ang_ff < -QUARTER16) begin
               cz_load = ang_ff + HALF16;
               neg_in  = 1'b1;
            end else begin
               neg_in  = 1'b0;
            end
            state_in = S_ROT;
         end
         S_ROT: begin
            cctl.step = 1'b1;
            if (cdone) begin
               state_in = S_ROTE;
            end
         end
         S_ROTE: begin
            if (pass_ff) begin
               state_in = S_MULS;
            end else begin
               pass_in  = 1'b1;
               state_in = S_SEL;
            end
         end
         S_MULS: begin
            prod_in  = $signed({1'b0, weight_ff}) * sn_ff;
            state_in = S_MULC;
         end
         S_MULC: begin
            prod_in  = $signed({1'b0, weight_ff}) * cn_ff;
            state_in = S_SUM;
         end
         S_SUM: begin
            state_in = S_VLOAD;
         end
         S_VLOAD: begin
            zero_in   = (xs_ff == '0) && (ys_ff == '0);
            cctl.load = 1'b1;
            cctl.vec  = 1'b1;
            if (vx < 0) begin
               cx_load = -vx;
               cy_load = -vy;
               cz_load = HALF16;
            end else begin
               cx_load = vx;
               cy_load = vy;
               cz_load = '0;
            end
            state_in = S_VEC;
         end
         S_VEC: begin
            cctl.step = 1'b1;
            cctl.vec  = 1'b1;
            if (cdone) begin
               state_in = S_WRAPZ;
            end
         end
         S_WRAPZ: begin
            if (cz < 0) begin
               ang_in = cz + FULL16;
            end else if (cz >= FULL16) begin
               ang_in = cz - FULL16;
            end else begin
               ang_in = cz;
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               prev_in      = q_val;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         corr_ff      <= CORR_RESET;
         weight_ff    <= WEIGHT_RESET;
         prev_ff      <= PREV_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
         if (csr_write) begin
            case (csr_index)
               CSR_IDX_CORR:   corr_ff   <= csr_wdata;
               CSR_IDX_WEIGHT: weight_ff <= csr_wdata;
               default:        ;
            endcase
         end
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      dir_ff  <= dir_in;
      ang_ff  <= ang_in;
      neg_ff  <= neg_in;
      pass_ff <= pass_in;
      zero_ff <= zero_in;
      if (req_valid && req_ready) begin
         enc_ff  <= req_raw_word[13:0];
         sail_ff <= req_sail_angle[15:7];
         head_ff <= req_heading[15:7];
      end
      if (state_ff == S_ROTE) begin
         if (pass_ff) begin
            sn_ff <= clamp15(ry);
            cn_ff <= clamp15(rx);
         end else begin
            sp_ff <= clamp15(ry);
            cp_ff <= clamp15(rx);
         end
      end
      if (state_ff == S_MULS) begin
         prod_s_ff <= prod_in;
      end
      if (state_ff == S_MULC) begin
         prod_c_ff <= prod_in;
      end
      if (state_ff == S_SUM) begin
         ys_ff <= 19'(sp_ff) + 19'(prod_s_ff >>> 8);
         xs_ff <= 19'(cp_ff) + 19'(prod_c_ff >>> 8);
      end
      if (state_ff == S_FIN && out_free) begin
         rsp_raw_ff <= dir_ff;
         rsp_dir_ff <= q_val;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_raw_direction  = rsp_raw_ff;
   assign rsp_wind_direction = rsp_dir_ff;

endmodule

// File: rtl/core/wvcf_checker.sv
`timescale 1ns / 1ps
module wvcf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [8:0]  rsp_raw_direction,
   input logic [15:0] rsp_wind_direction
);

   a_dir_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_wind_direction < 16'd46080)
      else $error("filtered direction out of range");

   a_raw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_raw_direction < 9'd360)
      else $error("raw direction out of range");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_wind_direction))
      else $error("stalled response changed");

endmodule

bind wind_vane_circular_filter wvcf_checker u_wvcf_checker (.*);

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import wvcf_pkg::*;

   localparam int STEPS        = CORDIC_STEPS_DEF;
   localparam int RANDOM_ITEMS = 950;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 200;

   // working angles in 2^-16 degree
   localparam int ANG_FULL    = 360 * 65536;
   localparam int ANG_HALF    = 180 * 65536;
   localparam int ANG_QUARTER = 90 * 65536;

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic        csr_index;
   logic [8:0]  csr_wdata;
   logic        req_valid;
   logic        req_ready;
   logic [15:0] req_raw_word;
   logic [15:0] req_sail_angle;
   logic [15:0] req_heading;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [8:0]  rsp_raw_direction;
   logic [15:0] rsp_wind_direction;

   typedef struct packed {
      logic [8:0]  raw_dir;
      logic [15:0] wind_dir;
   } direction_type;

   // directed row: the expected result is only trusted when pinned is set
   typedef struct {
      logic [15:0]   raw_word;
      logic [15:0]   sail;
      logic [15:0]   head;
      logic          pinned;
      direction_type pin;
   } vane_row_type;

   direction_type expected_directions[$];
   vane_row_type  vane_rows[$];

   // predictor copy of the block state and registers
   logic signed [8:0] model_corr;
   logic [8:0]        model_weight;
   logic [15:0]       model_prev;

   int  cycle_count;
   int  error_count;
   bit  stall_enable;

   wind_vane_circular_filter DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_raw_word       (req_raw_word),
      .req_sail_angle     (req_sail_angle),
      .req_heading        (req_heading),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_raw_direction  (rsp_raw_direction),
      .rsp_wind_direction (rsp_wind_direction)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // >>> on int is an arithmetic (floor) shift
   function automatic int rotate_table(input int i);
      return int'(atan_lookup(i[4:0]));
   endfunction

   // rotation mode: sine and cosine of z, Q1.15, clamped to +-32767
   task automatic rotate_sincos(input int z, output int s, output int c);
      int x;
      int y;
      int t;
      bit flip;
      x = int'(INV_GAIN);
      y = 0;
      flip = 1'b0;
      while (z >= ANG_FULL) z -= ANG_FULL;
      if (z > ANG_HALF) z -= ANG_FULL;
      if (z > ANG_QUARTER) begin
         z -= ANG_HALF;
         flip = 1'b1;
      end else if (z < -ANG_QUARTER) begin
         z += ANG_HALF;
         flip = 1'b1;
      end
      for (int i = 0; i < STEPS && i < 24; i++) begin
         if (z >= 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z -= rotate_table(i);
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z += rotate_table(i);
         end
         x = t;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      s = (y > 32767) ? 32767 : (y < -32767) ? -32767 : y;
      c = (x > 32767) ? 32767 : (x < -32767) ? -32767 : x;
   endtask

   // vectoring mode: angle of (x, y) in 0..ANG_FULL-1; zero vector gives 0
   function automatic int vector_angle(input int y, input int x);
      int z;
      int t;
      z = 0;
      if (x == 0 && y == 0) return 0;
      x = x * 256;
      y = y * 256;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = ANG_HALF;
      end
      for (int i = 0; i < STEPS && i < 24; i++) begin
         if (y < 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z -= rotate_table(i);
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z += rotate_table(i);
         end
         x = t;
      end
      while (z < 0) z += ANG_FULL;
      while (z >= ANG_FULL) z -= ANG_FULL;
      return z;
   endfunction

   // works out one transaction's result and advances the filter state
   task automatic predict_direction(input logic [15:0] raw_word, input logic [15:0] sail,
                                    input logic [15:0] head, output direction_type r);
      int reading;
      int dir;
      int sp, cp, sn, cn;
      int ys, xs, w;
      int q;
      reading = int'(raw_word[13:0]) * 360 / 16384 + int'(model_corr);
      if (reading < 0) reading += 360;
      dir = (reading + int'(sail[15:7])) % 360;
      dir = (dir + int'(head[15:7])) % 360;
      rotate_sincos(int'(model_prev) << 9, sp, cp);
      rotate_sincos(dir * 65536, sn, cn);
      w = int'(model_weight);
      ys = sp + ((w * sn) >>> 8);
      xs = cp + ((w * cn) >>> 8);
      q = (vector_angle(ys, xs) + 256) >>> 9;
      if (q >= 46080) q -= 46080;
      model_prev = q[15:0];
      r.raw_dir  = dir[8:0];
      r.wind_dir = q[15:0];
   endtask

   task automatic write_register(input logic index, input logic [8:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (index == CSR_IDX_CORR) model_corr = value;
      else model_weight = value;
      @(posedge clock);
   endtask

   // one transaction on the request channel; prediction taken at acceptance.
   // valid stays up after acceptance so that the next transaction can follow
   // on the same edge; idling or wait_idle drops it.
   task automatic send_reading(input logic [15:0] raw_word, input logic [15:0] sail,
                               input logic [15:0] head, input bit pinned,
                               input direction_type pin);
      direction_type r;
      if (stall_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_raw_word   <= raw_word;
      req_sail_angle <= sail;
      req_heading    <= head;
      do @(posedge clock); while (!req_ready);
      predict_direction(raw_word, sail, head, r);
      if (pinned && r !== pin) begin
         $error("directed row mispredicted: %0d/%0d", r.raw_dir, r.wind_dir);
         error_count++;
      end
      expected_directions.push_back(pinned ? pin : r);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_directions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic vane_row_type row(input logic [15:0] rw, input logic [15:0] s,
                                        input logic [15:0] h);
      vane_row_type v;
      v.raw_word = rw;
      v.sail     = s;
      v.head     = h;
      v.pinned   = 1'b0;
      v.pin      = '0;
      return v;
   endfunction

   // random receiver stalls while stall_enable is set
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_enable && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // response checker: each accepted transaction against the oldest expectation
   always @(posedge clock) begin
      direction_type exp_dir;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_directions.size() == 0) begin
            $error("unexpected response transaction");
            error_count++;
         end else begin
            exp_dir = expected_directions.pop_front();
            if (rsp_raw_direction !== exp_dir.raw_dir) begin
               $error("raw_direction: expected %0d, actual %0d",
                      exp_dir.raw_dir, rsp_raw_direction);
               error_count++;
            end
            if (rsp_wind_direction !== exp_dir.wind_dir) begin
               $error("wind_direction: expected %0d, actual %0d",
                      exp_dir.wind_dir, rsp_wind_direction);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      vane_row_type v;
      direction_type pin;
      int weights[6];
      int corrs[6];
      cycle_count    = 0;
      error_count    = 0;
      stall_enable   = 1'b0;
      reset          = 1'b1;
      csr_write      = 1'b0;
      csr_index      = CSR_IDX_CORR;
      csr_wdata      = '0;
      req_valid      = 1'b0;
      req_raw_word   = '0;
      req_sail_angle = '0;
      req_heading    = '0;
      model_corr     = CORR_RESET;
      model_weight   = WEIGHT_RESET;
      model_prev     = PREV_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table at reset values
      // zero encoder, zero angles: raw 360-26 = 334
      v = row(16'h0000, 16'h0000, 16'h0000);
      v.pinned = 1'b1;
      vane_rows.push_back(v);
      vane_rows.push_back(row(16'hFFFF, 16'hFFFF, 16'hFFFF));  // all bits set, masked
      vane_rows.push_back(row(16'hC000, 16'd46079, 16'd46079)); // frame bits only
      vane_rows.push_back(row(16'h3FFF, 16'd0, 16'd46079));
      vane_rows.push_back(row(16'h2000, 16'd23040, 16'd0));
      vane_rows.push_back(row(16'h1234, 16'h8000, 16'h7FFF));
      foreach (vane_rows[i]) begin
         pin.raw_dir  = 9'd334;
         pin.wind_dir = '0;
         if (vane_rows[i].pinned) begin
            predict_direction(vane_rows[i].raw_word, vane_rows[i].sail,
                              vane_rows[i].head, pin);
            // the raw angle is easy to read off; wind comes from the predictor
            model_prev = PREV_RESET;
            if (pin.raw_dir != 9'd334) begin
               $error("raw_direction: expected %0d, actual %0d", 9'd334, pin.raw_dir);
               error_count++;
            end
         end
         send_reading(vane_rows[i].raw_word, vane_rows[i].sail, vane_rows[i].head,
                      1'b0, pin);
      end
      wait_idle();

      // extremes of both registers, incl. out-of-range codes
      write_register(CSR_IDX_CORR, 9'h100);   // -256
      write_register(CSR_IDX_WEIGHT, 9'd0);   // new sample ignored
      send_reading(16'h0000, 16'd0, 16'd0, 1'b0, pin);
      send_reading(16'h3FFF, 16'hFFFF, 16'hFFFF, 1'b0, pin);
      wait_idle();
      write_register(CSR_IDX_CORR, 9'h0FF);   // +255
      write_register(CSR_IDX_WEIGHT, 9'h1FF); // 511/256
      send_reading(16'h3FFF, 16'hFFFF, 16'hFFFF, 1'b0, pin);
      send_reading(16'h0000, 16'd0, 16'd0, 1'b0, pin);
      wait_idle();
      // opposite vectors of equal weight: drives the zero-vector case
      write_register(CSR_IDX_CORR, 9'd0);
      write_register(CSR_IDX_WEIGHT, 9'd256);
      for (int k = 0; k < 4; k++)
         send_reading(16'h0000, 16'(((int'(model_prev) / 128 + 180) % 360) << 7), 16'd0,
                      1'b0, pin);
      send_reading(16'h0000, 16'd90 << 7, 16'd0, 1'b0, pin);
      send_reading(16'h0000, 16'd270 << 7, 16'd0, 1'b0, pin);
      wait_idle();

      // random part over several register settings
      weights = '{0, 256, 511, 16, 64, 128};
      corrs   = '{-180, 180, -26, 0, -256, 255};
      stall_enable = 1'b1;
      for (int ph = 0; ph < 6; ph++) begin
         write_register(CSR_IDX_CORR, 9'(corrs[ph]));
         write_register(CSR_IDX_WEIGHT, 9'(weights[ph]));
         if (ph == 5) stall_enable = 1'b0; // last stretch runs flat out
         for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
            if ($urandom_range(0, 9) < 8)
               send_reading(16'($urandom()), 16'($urandom_range(0, 46079)),
                            16'($urandom_range(0, 46079)), 1'b0, pin);
            else
               send_reading(16'($urandom()), 16'($urandom()), 16'($urandom()),
                            1'b0, pin);
         end
         wait_idle();
      end

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: wind_vane_circular_filter.f
rtl/core/wvcf_pkg.sv
rtl/core/wvcf_cordic.sv
rtl/core/wind_vane_circular_filter.sv
rtl/core/wvcf_checker.sv
tb/testbench.sv
